FILE: hdl/pid_positional_tracking_antiwindup_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i and disabled
// while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PID_POSITIONAL_TRACKING_ANTIWINDUP_DEFINES_SVH
`define PID_POSITIONAL_TRACKING_ANTIWINDUP_DEFINES_SVH

// Same-cycle implication.
`define PPTAW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PPTAW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pptaw_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Types, register map, sequencer states and saturation helpers shared by
// the PID controller modules.
// ----------------------------------------------------------------------------
package pptaw_pkg;

  // Multiply-accumulate widths: operand up to 43 bits signed, 16-bit digit.
  localparam int OPA_W   = 43;
  localparam int COEF_W  = 32;
  localparam int DIGIT_W = COEF_W / 2;
  localparam int ACC_W   = OPA_W + DIGIT_W + 1;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_SETPOINT_WEIGHT = 3'd1,
    REG_INTEGRAL_GAIN   = 3'd2,
    REG_DERIV_POLE      = 3'd3,
    REG_DERIV_GAIN      = 3'd4,
    REG_OUT_MIN         = 3'd5,
    REG_OUT_MAX         = 3'd6,
    REG_BACKCALC_GAIN   = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WSP_L, ST_WSP_H, ST_ERR,
    ST_P_L,   ST_P_H,
    ST_T1_L,  ST_T1_H,
    ST_T2_L,  ST_T2_H,  ST_DER,
    ST_I_L,   ST_I_H,   ST_INT,
    ST_TRK,
    ST_SUM,   ST_CLAMP,
    ST_BC_L,  ST_BC_H,  ST_BCFIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [30:0]        prop_gain;
    logic [30:0]        setpoint_weight;
    logic [30:0]        integral_gain;
    logic [16:0]        deriv_pole;
    logic [30:0]        deriv_gain;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
    logic [16:0]        backcalc_gain;
  } cfg_t;

  typedef struct packed {
    logic en;  // update the accumulator
    logic hi;  // high coefficient digit: shift and accumulate
  } mac_ctl_t;

  localparam logic [30:0]        PROP_GAIN_RST       = 31'd65536;
  localparam logic [30:0]        SETPOINT_WEIGHT_RST = 31'd65536;
  localparam logic [30:0]        INTEGRAL_GAIN_RST   = 31'd0;
  localparam logic [16:0]        DERIV_POLE_RST      = 17'd0;
  localparam logic [30:0]        DERIV_GAIN_RST      = 31'd0;
  localparam logic signed [31:0] OUT_MIN_RST         = 32'sd0;
  localparam logic signed [31:0] OUT_MAX_RST         = 32'sd6553600;
  localparam logic [16:0]        BACKCALC_GAIN_RST   = 17'd0;

  // Saturate to 40 bits signed.
  function automatic logic signed [39:0] sat40(logic signed [ACC_W-1:0] x);
    logic signed [39:0] r;
    if ((x[ACC_W-1:39] == '0) || (x[ACC_W-1:39] == '1)) begin
      r = x[39:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {39{1'b0}}};
    end else begin
      r = {1'b0, {39{1'b1}}};
    end
    return r;
  endfunction

  // Saturate to 32 bits signed.
  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] x);
    logic signed [31:0] r;
    if ((x[ACC_W-1:31] == '0) || (x[ACC_W-1:31] == '1)) begin
      r = x[31:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hdl/pptaw_regs.sv
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style write/read access to the six controller coefficients and the two
// output limits.
// ----------------------------------------------------------------------------
module pptaw_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pptaw_pkg::ADDR_W-1:0]  paddr,
  input  logic [pptaw_pkg::DATA_W-1:0]  pwdata,
  output logic [pptaw_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output pptaw_pkg::cfg_t               cfg_o
);

  pptaw_pkg::cfg_t      cfg_q;
  pptaw_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = pptaw_pkg::reg_idx_e'(paddr[pptaw_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= pptaw_pkg::PROP_GAIN_RST;
      cfg_q.setpoint_weight <= pptaw_pkg::SETPOINT_WEIGHT_RST;
      cfg_q.integral_gain   <= pptaw_pkg::INTEGRAL_GAIN_RST;
      cfg_q.deriv_pole      <= pptaw_pkg::DERIV_POLE_RST;
      cfg_q.deriv_gain      <= pptaw_pkg::DERIV_GAIN_RST;
      cfg_q.out_min         <= pptaw_pkg::OUT_MIN_RST;
      cfg_q.out_max         <= pptaw_pkg::OUT_MAX_RST;
      cfg_q.backcalc_gain   <= pptaw_pkg::BACKCALC_GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        pptaw_pkg::REG_PROP_GAIN:       cfg_q.prop_gain       <= pwdata[30:0];
        pptaw_pkg::REG_SETPOINT_WEIGHT: cfg_q.setpoint_weight <= pwdata[30:0];
        pptaw_pkg::REG_INTEGRAL_GAIN:   cfg_q.integral_gain   <= pwdata[30:0];
        pptaw_pkg::REG_DERIV_POLE:      cfg_q.deriv_pole      <= pwdata[16:0];
        pptaw_pkg::REG_DERIV_GAIN:      cfg_q.deriv_gain      <= pwdata[30:0];
        pptaw_pkg::REG_OUT_MIN:         cfg_q.out_min         <= $signed(pwdata);
        pptaw_pkg::REG_OUT_MAX:         cfg_q.out_max         <= $signed(pwdata);
        pptaw_pkg::REG_BACKCALC_GAIN:   cfg_q.backcalc_gain   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pptaw_pkg::REG_PROP_GAIN:       prdata = {1'b0, cfg_q.prop_gain};
      pptaw_pkg::REG_SETPOINT_WEIGHT: prdata = {1'b0, cfg_q.setpoint_weight};
      pptaw_pkg::REG_INTEGRAL_GAIN:   prdata = {1'b0, cfg_q.integral_gain};
      pptaw_pkg::REG_DERIV_POLE:      prdata = {15'd0, cfg_q.deriv_pole};
      pptaw_pkg::REG_DERIV_GAIN:      prdata = {1'b0, cfg_q.deriv_gain};
      pptaw_pkg::REG_OUT_MIN:         prdata = cfg_q.out_min;
      pptaw_pkg::REG_OUT_MAX:         prdata = cfg_q.out_max;
      pptaw_pkg::REG_BACKCALC_GAIN:   prdata = {15'd0, cfg_q.backcalc_gain};
      default:                        prdata = '0;
    endcase
  end

endmodule

FILE: hdl/pptaw_mac.sv
// ----------------------------------------------------------------------------
// PID controller shared multiplier
// Two-pass Q16 product: floor(a * c / 2^16) built from the low and the high
// 16-bit digit of the coefficient on one 43x17 signed multiplier.
// ----------------------------------------------------------------------------
module pptaw_mac (
  input  logic                                 clk_i,
  input  pptaw_pkg::mac_ctl_t                  ctl_i,
  input  logic signed [pptaw_pkg::OPA_W-1:0]   opa_i,
  input  logic [pptaw_pkg::COEF_W-1:0]         coef_i,
  output logic signed [pptaw_pkg::ACC_W-1:0]   acc_o
);

  logic [pptaw_pkg::DIGIT_W-1:0]       digit;
  logic signed [pptaw_pkg::ACC_W-1:0]  prod;
  logic signed [pptaw_pkg::ACC_W-1:0]  acc_d;
  logic signed [pptaw_pkg::ACC_W-1:0]  acc_q;

  assign digit = ctl_i.hi ? coef_i[pptaw_pkg::COEF_W-1:pptaw_pkg::DIGIT_W]
                          : coef_i[pptaw_pkg::DIGIT_W-1:0];
  assign prod  = opa_i * $signed({1'b0, digit});

  // Low pass keeps the full product; high pass floors it by 2^16 and adds.
  assign acc_d = ctl_i.hi ? (acc_q >>> pptaw_pkg::DIGIT_W) + prod : prod;
  assign acc_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

endmodule

FILE: hdl/pptaw_core.sv
// ----------------------------------------------------------------------------
// PID controller sequencer and datapath
// Steps one sample through the P, D, I and anti-windup terms on the shared
// multiplier, keeps the controller state and holds the result register.
// ----------------------------------------------------------------------------
`include "pid_positional_tracking_antiwindup_defines.svh"

module pptaw_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pptaw_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  setpoint_i,
  input  logic signed [31:0]  measurement_i,
  input  logic signed [31:0]  track_value_i,
  input  logic                active_mode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  drive_o,
  output logic                windup_flag_o
);

  localparam int AW = pptaw_pkg::ACC_W;
  localparam int OW = pptaw_pkg::OPA_W;

  pptaw_pkg::state_e    state_q, state_d;
  pptaw_pkg::mac_ctl_t  mac_ctl;

  logic signed [OW-1:0]            opa;
  logic [pptaw_pkg::COEF_W-1:0]    coef;
  logic signed [AW-1:0]            acc;
  logic                            out_load;

  // Sample and intermediates
  logic signed [31:0]  sp_q, pv_q, tv_q;
  logic                act_q;
  logic signed [39:0]  e_q, p_q, i_q;
  logic signed [33:0]  t1_q;
  logic signed [31:0]  d_q, u_q;
  logic signed [41:0]  raw_q;
  logic                flag_q;

  // Controller state
  logic signed [39:0]  integ_q;
  logic signed [31:0]  deriv_q, last_q;

  // Result register
  logic                out_valid_q;
  logic signed [31:0]  drive_q;
  logic                wl_q;

  logic signed [31:0]  tv_lo, tv_clamp;
  logic signed [41:0]  u_lo, u_clamp;
  logic                flag_c;

  pptaw_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .opa_i  (opa),
    .coef_i (coef),
    .acc_o  (acc)
  );

  // Tracking target and output clamp: lower limit first, upper limit last.
  assign tv_lo    = (tv_q < cfg_i.out_min) ? cfg_i.out_min : tv_q;
  assign tv_clamp = (tv_lo > cfg_i.out_max) ? cfg_i.out_max : tv_lo;
  assign u_lo     = (raw_q < 42'(cfg_i.out_min)) ? 42'(cfg_i.out_min) : raw_q;
  assign u_clamp  = (u_lo > 42'(cfg_i.out_max)) ? 42'(cfg_i.out_max) : u_lo;
  assign flag_c   = act_q && (u_clamp != raw_q) && (cfg_i.backcalc_gain != '0);

  // Operand select for the shared multiplier
  always_comb begin
    opa  = '0;
    coef = '0;
    case (state_q)
      pptaw_pkg::ST_WSP_L, pptaw_pkg::ST_WSP_H: begin
        opa  = OW'(sp_q);
        coef = {1'b0, cfg_i.setpoint_weight};
      end
      pptaw_pkg::ST_P_L, pptaw_pkg::ST_P_H: begin
        opa  = OW'(e_q);
        coef = {1'b0, cfg_i.prop_gain};
      end
      pptaw_pkg::ST_T1_L, pptaw_pkg::ST_T1_H: begin
        opa  = OW'(deriv_q);
        coef = {15'd0, cfg_i.deriv_pole};
      end
      pptaw_pkg::ST_T2_L, pptaw_pkg::ST_T2_H: begin
        opa  = OW'(pv_q) - OW'(last_q);
        coef = {1'b0, cfg_i.deriv_gain};
      end
      pptaw_pkg::ST_I_L, pptaw_pkg::ST_I_H: begin
        opa  = OW'(sp_q) - OW'(pv_q);
        coef = {1'b0, cfg_i.integral_gain};
      end
      pptaw_pkg::ST_BC_L, pptaw_pkg::ST_BC_H: begin
        opa  = OW'(u_q) - OW'(raw_q);
        coef = {15'd0, cfg_i.backcalc_gain};
      end
      default: ;
    endcase
  end

  // Next state and control
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    mac_ctl    = '0;
    out_load   = 1'b0;
    case (state_q)
      pptaw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = pptaw_pkg::ST_WSP_L;
        end
      end
      pptaw_pkg::ST_WSP_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_WSP_H;
      end
      pptaw_pkg::ST_WSP_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_ERR;
      end
      pptaw_pkg::ST_ERR:   state_d = pptaw_pkg::ST_P_L;
      pptaw_pkg::ST_P_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_P_H;
      end
      pptaw_pkg::ST_P_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_T1_L;
      end
      pptaw_pkg::ST_T1_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_T1_H;
      end
      pptaw_pkg::ST_T1_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_T2_L;
      end
      pptaw_pkg::ST_T2_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_T2_H;
      end
      pptaw_pkg::ST_T2_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_DER;
      end
      pptaw_pkg::ST_DER: begin
        state_d = act_q ? pptaw_pkg::ST_I_L : pptaw_pkg::ST_TRK;
      end
      pptaw_pkg::ST_I_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_I_H;
      end
      pptaw_pkg::ST_I_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_INT;
      end
      pptaw_pkg::ST_INT:   state_d = pptaw_pkg::ST_SUM;
      pptaw_pkg::ST_TRK:   state_d = pptaw_pkg::ST_SUM;
      pptaw_pkg::ST_SUM:   state_d = pptaw_pkg::ST_CLAMP;
      pptaw_pkg::ST_CLAMP: begin
        state_d = flag_c ? pptaw_pkg::ST_BC_L : pptaw_pkg::ST_DONE;
      end
      pptaw_pkg::ST_BC_L: begin
        mac_ctl.en = 1'b1;
        state_d    = pptaw_pkg::ST_BC_H;
      end
      pptaw_pkg::ST_BC_H: begin
        mac_ctl = '{en: 1'b1, hi: 1'b1};
        state_d = pptaw_pkg::ST_BCFIX;
      end
      pptaw_pkg::ST_BCFIX: state_d = pptaw_pkg::ST_DONE;
      pptaw_pkg::ST_DONE: begin
        // Hold until the result register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = pptaw_pkg::ST_IDLE;
        end
      end
      default: state_d = pptaw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pptaw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pptaw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          sp_q  <= setpoint_i;
          pv_q  <= measurement_i;
          tv_q  <= track_value_i;
          act_q <= active_mode_i;
        end
      end
      pptaw_pkg::ST_ERR: begin
        e_q <= pptaw_pkg::sat40(AW'(pptaw_pkg::sat40(acc)) - AW'(pv_q));
      end
      pptaw_pkg::ST_T1_L:  p_q  <= pptaw_pkg::sat40(acc);
      pptaw_pkg::ST_T2_L:  t1_q <= acc[33:0];
      pptaw_pkg::ST_DER:   d_q  <= pptaw_pkg::sat32(AW'(t1_q) - acc);
      pptaw_pkg::ST_INT:   i_q  <= pptaw_pkg::sat40(AW'(integ_q) + acc);
      pptaw_pkg::ST_TRK: begin
        i_q <= pptaw_pkg::sat40(AW'(tv_clamp) - AW'(p_q) - AW'(d_q));
      end
      pptaw_pkg::ST_SUM:   raw_q <= 42'(p_q) + 42'(i_q) + 42'(d_q);
      pptaw_pkg::ST_CLAMP: begin
        u_q    <= u_clamp[31:0];
        flag_q <= flag_c;
      end
      pptaw_pkg::ST_BCFIX: i_q <= pptaw_pkg::sat40(AW'(i_q) + acc);
      default: ;
    endcase
    if (out_load) begin
      drive_q <= u_q;
      wl_q    <= flag_q;
    end
  end

  // Controller state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      deriv_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        integ_q     <= i_q;
        deriv_q     <= d_q;
        last_q      <= pv_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign windup_flag_o = wl_q;

  `PPTAW_ASSERT_IMP(a_windup_at_limit,
    out_valid_o && windup_flag_o,
    (drive_o == cfg_i.out_min) || (drive_o == cfg_i.out_max),
    "windup flag set while drive is not at a limit")

  `PPTAW_ASSERT_IMP(a_drive_in_limits,
    out_valid_o && ($signed(cfg_i.out_min) <= $signed(cfg_i.out_max)),
    ($signed(drive_o) >= $signed(cfg_i.out_min)) &&
      ($signed(drive_o) <= $signed(cfg_i.out_max)),
    "drive outside ordered output limits")

  `PPTAW_ASSERT_IMP(a_tracking_no_flag,
    (state_q == pptaw_pkg::ST_DONE) && !act_q,
    !flag_q,
    "anti-windup flagged on a tracking sample")

  `PPTAW_ASSERT_NXT(a_state_commit,
    state_q != pptaw_pkg::ST_DONE,
    $stable(last_q) && $stable(integ_q) && $stable(deriv_q),
    "controller state changed outside commit")

endmodule

FILE: hdl/pid_positional_tracking_antiwindup.sv
// ----------------------------------------------------------------------------
// PID controller with tracking and back-calculation anti-windup
// Setpoint-weighted P, filtered derivative on measurement, integral with
// output tracking, output clamp and back-calculated integral correction.
// ----------------------------------------------------------------------------
// Sequencing: P and D terms, then the integral in active mode or tracking in
//   tracking mode, then back-calculation when anti-windup corrects the integral.
// Samples: a new one is taken only after the last result is loaded; one 43x17
//   multiplier does each product in two passes (low, high coefficient digit).
// Reset: clears integral, derivative and last measurement, loads register
//   defaults, and leaves the block idle and ready.
module pid_positional_tracking_antiwindup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pptaw_pkg::ADDR_W-1:0]  paddr,
  input  logic [pptaw_pkg::DATA_W-1:0]  pwdata,
  output logic [pptaw_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            setpoint_i,
  input  logic signed [31:0]            measurement_i,
  input  logic signed [31:0]            track_value_i,
  input  logic                          active_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            drive_o,
  output logic                          windup_flag_o
);

  pptaw_pkg::cfg_t cfg;

  pptaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pptaw_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .track_value_i (track_value_i),
    .active_mode_i (active_mode_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_o       (drive_o),
    .windup_flag_o (windup_flag_o)
  );

endmodule
